>>> hdl/plfm_pkg.sv
// ----------------------------------------------------------------------------
// plfm_pkg
// Types and codes shared by the price level matcher: operation kinds,
// result status codes, controller states and the slot table word.
// ----------------------------------------------------------------------------
package plfm_pkg;

  localparam int unsigned ID_W        = 32;
  localparam int unsigned QTY_W       = 32;
  localparam int unsigned PRICE_W     = 32;
  // Upper bound on trades produced by one match
  localparam int unsigned MAX_TRADES  = 16;
  localparam int unsigned TRADE_CNT_W = $clog2(MAX_TRADES);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_MATCH  = 2'd1,
    KIND_CANCEL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_MISMATCH  = 3'd1,
    ST_FULL      = 3'd2,
    ST_TRADE     = 3'd3,
    ST_NOFILL    = 3'd4,
    ST_CANCELLED = 3'd5,
    ST_NOTFOUND  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MATCH = 2'd1,
    S_SCAN  = 2'd2,
    S_EMIT  = 2'd3
  } state_e;

  // One resting order as stored in the slot table
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [QTY_W-1:0] qty;
  } slot_t;

endpackage

>>> hdl/price_level_fifo_matcher_core.sv
// ----------------------------------------------------------------------------
// price_level_fifo_matcher_core
// One order book price level: a time-ordered queue of resting orders held
// in a circular slot table memory, with add, match and cancel operations.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+--------------------------------
// in       | in  | in_valid_i / in_stall_o   | kind, order_id, side, price,
//          |     |                           | quantity
// out      | out | out_valid_o / out_stall_i | status, buy_id, sell_id,
//          |     |                           | trade_qty, resting_left,
//          |     |                           | incoming_left, level_empty, last
// cfg      | in  | cfg_valid_i / cfg_ready_o | level_price (cfg_data_i)
//
// Add, and match or cancel that finish at once: accepted, then the result.
// Match: accepted, then one trade per cycle unless the output stalls; the slot
//   table read of the next head is issued while the current trade is formed.
// Cancel: the slot table is walked one entry per cycle from the head, and the
//   entries behind the hit move up on the way; then the result is given.
// Reset clears the queue pointers and count; the slot table is not cleared.
// An output stall holds the match and result states and the match read data.

module price_level_fifo_matcher_core
  import plfm_pkg::*;
#(
  parameter int unsigned LEVEL_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [PRICE_W-1:0] cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [ID_W-1:0]    order_id_i,
  input  logic               side_i,
  input  logic [PRICE_W-1:0] price_i,
  input  logic [QTY_W-1:0]   quantity_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [ID_W-1:0]    buy_id_o,
  output logic [ID_W-1:0]    sell_id_o,
  output logic [QTY_W-1:0]   trade_qty_o,
  output logic [QTY_W-1:0]   resting_left_o,
  output logic [QTY_W-1:0]   incoming_left_o,
  output logic               level_empty_o,
  output logic               last_o
);

  localparam int unsigned IdxW = $clog2(LEVEL_DEPTH);
  localparam int unsigned CntW = $clog2(LEVEL_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(LEVEL_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(LEVEL_DEPTH);
  localparam logic [TRADE_CNT_W-1:0] LastTrade = TRADE_CNT_W'(MAX_TRADES - 1);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [IdxW-1:0]        head_q, head_d;
  logic [IdxW-1:0]        tail_q, tail_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [PRICE_W-1:0]     price_q;
  logic [ID_W-1:0]        oid_q, oid_d;
  logic                   side_q, side_d;
  logic [QTY_W-1:0]       left_q, left_d;
  logic [TRADE_CNT_W-1:0] ntr_q, ntr_d;
  logic [CntW-1:0]        scan_pos_q, scan_pos_d;
  logic [IdxW-1:0]        scan_addr_q, scan_addr_d;
  logic [IdxW-1:0]        prev_addr_q, prev_addr_d;
  logic                   found_q, found_d;
  status_e                res_q, res_d;

  // Slot table memory
  slot_t                  mem_q [LEVEL_DEPTH];
  slot_t                  rdata_q;
  logic                   mem_we, mem_re;
  logic [IdxW-1:0]        mem_waddr, mem_raddr;
  slot_t                  mem_wdata;

  // Output register
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [ID_W-1:0]        out_buy_q, out_sell_q;
  logic [QTY_W-1:0]       out_tq_q, out_rl_q, out_il_q;
  logic                   out_empty_q, out_last_q;
  logic                   out_load;
  status_e                out_status_d;
  logic [ID_W-1:0]        out_buy_d, out_sell_d;
  logic [QTY_W-1:0]       out_tq_d, out_rl_d, out_il_d;
  logic                   out_empty_d, out_last_d;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] wrap_dec(input logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - IdxW'(1);
  endfunction

  // --------------------------------------------------------------------------
  // Shared conditions
  // --------------------------------------------------------------------------
  logic            in_xfer, can_load;
  kind_e           kind;
  logic            price_ok, full, empty;
  // match step
  logic [QTY_W-1:0] fill_amt, new_left, rest_left;
  logic            removed, match_go;
  logic [CntW-1:0] cnt_after;
  // cancel walk
  logic            id_hit, found_now, last_pos;

  assign kind      = kind_e'(kind_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign can_load  = !out_valid_q || !out_stall_i;
  assign price_ok  = (price_i == price_q);
  assign full      = (count_q == FullCnt);
  assign empty     = (count_q == '0);

  assign fill_amt  = (left_q < rdata_q.qty) ? left_q : rdata_q.qty;
  assign new_left  = left_q - fill_amt;
  assign rest_left = rdata_q.qty - fill_amt;
  assign removed   = (rest_left == '0);
  assign cnt_after = removed ? count_q - CntW'(1) : count_q;
  assign match_go  = (new_left != '0) && (cnt_after != '0) && (ntr_q != LastTrade);

  assign id_hit    = (rdata_q.id == oid_q);
  assign found_now = found_q || id_hit;
  assign last_pos  = (scan_pos_q == count_q - CntW'(1));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (kind)
            KIND_ADD:    state_d = S_EMIT;
            KIND_MATCH:  state_d = (quantity_i == '0 || empty) ? S_EMIT : S_MATCH;
            KIND_CANCEL: state_d = empty ? S_EMIT : S_SCAN;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_MATCH: begin
        if (can_load && !match_go) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (last_pos) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control: table access, queue pointers, results
  // --------------------------------------------------------------------------
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    oid_d        = oid_q;
    side_d       = side_q;
    left_d       = left_q;
    ntr_d        = ntr_q;
    scan_pos_d   = scan_pos_q;
    scan_addr_d  = scan_addr_q;
    prev_addr_d  = prev_addr_q;
    found_d      = found_q;
    res_d        = res_q;
    mem_we       = 1'b0;
    mem_waddr    = head_q;
    mem_wdata    = rdata_q;
    mem_re       = 1'b0;
    mem_raddr    = head_q;
    out_load     = 1'b0;
    out_status_d = res_q;
    out_buy_d    = '0;
    out_sell_d   = '0;
    out_tq_d     = '0;
    out_rl_d     = '0;
    out_il_d     = '0;
    out_empty_d  = empty;
    out_last_d   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          oid_d  = order_id_i;
          side_d = side_i;
          left_d = quantity_i;
          case (kind)
            KIND_ADD: begin
              if (!price_ok) begin
                res_d = ST_MISMATCH;
              end else if (full) begin
                res_d = ST_FULL;
              end else begin
                // rest the order at the tail
                mem_we    = 1'b1;
                mem_waddr = tail_q;
                mem_wdata = '{id: order_id_i, qty: quantity_i};
                tail_d    = wrap_inc(tail_q);
                count_d   = count_q + CntW'(1);
                res_d     = ST_ADDED;
              end
            end
            KIND_MATCH: begin
              res_d  = ST_NOFILL;
              ntr_d  = '0;
              mem_re = 1'b1;
            end
            KIND_CANCEL: begin
              res_d       = ST_NOTFOUND;
              mem_re      = 1'b1;
              scan_pos_d  = '0;
              scan_addr_d = head_q;
              found_d     = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_MATCH: begin
        if (can_load) begin
          // fill against the head and prefetch the following slot
          mem_we       = 1'b1;
          mem_waddr    = head_q;
          mem_wdata    = '{id: rdata_q.id, qty: rest_left};
          mem_re       = 1'b1;
          mem_raddr    = wrap_inc(head_q);
          left_d       = new_left;
          ntr_d        = ntr_q + TRADE_CNT_W'(1);
          count_d      = cnt_after;
          if (removed) begin
            head_d = wrap_inc(head_q);
          end
          out_load     = 1'b1;
          out_status_d = ST_TRADE;
          out_buy_d    = side_q ? rdata_q.id : oid_q;
          out_sell_d   = side_q ? oid_q : rdata_q.id;
          out_tq_d     = fill_amt;
          out_rl_d     = rest_left;
          out_il_d     = new_left;
          out_empty_d  = (cnt_after == '0);
          out_last_d   = !match_go;
        end
      end
      S_SCAN: begin
        // walk one slot per cycle; after the hit, move each slot up by one
        mem_re      = 1'b1;
        mem_raddr   = wrap_inc(scan_addr_q);
        scan_addr_d = wrap_inc(scan_addr_q);
        prev_addr_d = scan_addr_q;
        scan_pos_d  = scan_pos_q + CntW'(1);
        found_d     = found_now;
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = prev_addr_q;
          mem_wdata = rdata_q;
        end
        if (last_pos) begin
          if (found_now) begin
            res_d   = ST_CANCELLED;
            tail_d  = wrap_dec(tail_q);
            count_d = count_q - CntW'(1);
          end else begin
            res_d = ST_NOTFOUND;
          end
        end
      end
      S_EMIT: begin
        if (can_load) begin
          out_load     = 1'b1;
          out_status_d = res_q;
          out_il_d     = (res_q == ST_NOFILL) ? left_q : '0;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      price_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        price_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the item in progress
  always_ff @(posedge clk_i) begin
    oid_q       <= oid_d;
    side_q      <= side_d;
    left_q      <= left_d;
    ntr_q       <= ntr_d;
    scan_pos_q  <= scan_pos_d;
    scan_addr_q <= scan_addr_d;
    prev_addr_q <= prev_addr_d;
    found_q     <= found_d;
    res_q       <= res_d;
  end

  // Result payload, loaded together with the valid
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_buy_q    <= out_buy_d;
      out_sell_q   <= out_sell_d;
      out_tq_q     <= out_tq_d;
      out_rl_q     <= out_rl_d;
      out_il_q     <= out_il_d;
      out_empty_q  <= out_empty_d;
      out_last_q   <= out_last_d;
    end
  end

  // --------------------------------------------------------------------------
  // Slot table: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign buy_id_o        = out_buy_q;
  assign sell_id_o       = out_sell_q;
  assign trade_qty_o     = out_tq_q;
  assign resting_left_o  = out_rl_q;
  assign incoming_left_o = out_il_q;
  assign level_empty_o   = out_empty_q;
  assign last_o          = out_last_q;

`ifndef SYNTHESIS
  // Resting count never exceeds the table depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("resting count above level depth");

  // A partly filled resting order ends the match
  a_partial_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_TRADE && resting_left_o != '0) |-> last_o)
    else $error("trade with resting remainder not marked last");

  // A no fill comes only from an empty level or a zero quantity
  a_nofill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NOFILL) |-> (level_empty_o || incoming_left_o == '0))
    else $error("no fill on a non-empty level with quantity");

  // An empty level leaves head and tail together
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty level with head and tail apart");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for one order book price level. A short table of
// hand-picked operations runs first, then randomized add, match and cancel
// traffic under several level prices. A behavioral copy of the level
// predicts every status and trade, and each result is compared field by
// field in arrival order.
// ----------------------------------------------------------------------------
module testbench
  import plfm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BOOK_DEPTH      = 16;
  localparam logic [1:0]  KIND_UNUSED     = 2'd3;
  localparam logic        SIDE_BUY        = 1'b0;
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned STUCK_LIMIT     = 1000;
  localparam int unsigned FILL_BURST      = 18;
  localparam int unsigned ITEMS_PER_PHASE = 86;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_W-1:0]    order_id;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
  } order_t;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  buy_id;
    logic [ID_W-1:0]  sell_id;
    logic [QTY_W-1:0] trade_qty;
    logic [QTY_W-1:0] resting_left;
    logic [QTY_W-1:0] incoming_left;
    logic             level_empty;
    logic             last;
  } fill_report_t;

  // One directed step; a typed row carries its expected single result
  typedef struct packed {
    order_t           ord;
    logic             typed;
    status_e          exp_status;
    logic [QTY_W-1:0] exp_in_left;
    logic             exp_empty;
  } script_row_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [PRICE_W-1:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         kind_i     = '0;
  logic [ID_W-1:0]    order_id_i = '0;
  logic               side_i     = 1'b0;
  logic [PRICE_W-1:0] price_i    = '0;
  logic [QTY_W-1:0]   quantity_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic [ID_W-1:0]    buy_id_o;
  logic [ID_W-1:0]    sell_id_o;
  logic [QTY_W-1:0]   trade_qty_o;
  logic [QTY_W-1:0]   resting_left_o;
  logic [QTY_W-1:0]   incoming_left_o;
  logic               level_empty_o;
  logic               last_o;

  // Predicted level contents, packed from book_head
  logic [ID_W-1:0]    book_id  [BOOK_DEPTH];
  logic [QTY_W-1:0]   book_qty [BOOK_DEPTH];
  int unsigned        book_head  = 0;
  int unsigned        book_tail  = 0;
  int unsigned        book_count = 0;
  logic [PRICE_W-1:0] book_price = '0;

  fill_report_t awaited_reports[$];
  script_row_t  script[$];

  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned stall_left     = 0;
  bit          hold_off_req   = 1'b0;
  bit          quiet_mode     = 1'b0;

  price_level_fifo_matcher_core #(
    .LEVEL_DEPTH(BOOK_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .order_id_i     (order_id_i),
    .side_i         (side_i),
    .price_i        (price_i),
    .quantity_i     (quantity_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .buy_id_o       (buy_id_o),
    .sell_id_o      (sell_id_o),
    .trade_qty_o    (trade_qty_o),
    .resting_left_o (resting_left_o),
    .incoming_left_o(incoming_left_o),
    .level_empty_o  (level_empty_o),
    .last_o         (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Queue one predicted result; emptiness reflects the level after it
  function automatic void book_note(input status_e status, input logic [ID_W-1:0] buy,
                                    input logic [ID_W-1:0] sell, input logic [QTY_W-1:0] traded,
                                    input logic [QTY_W-1:0] rest,
                                    input logic [QTY_W-1:0] incoming, input logic last);
    fill_report_t r;
    r.status        = status;
    r.buy_id        = buy;
    r.sell_id       = sell;
    r.trade_qty     = traded;
    r.resting_left  = rest;
    r.incoming_left = incoming;
    r.level_empty   = (book_count == 0);
    r.last          = last;
    awaited_reports = {awaited_reports, r};
  endfunction

  // Apply one accepted order to the predicted level; return results queued
  function automatic int unsigned book_apply(input order_t o);
    logic [QTY_W-1:0] left;
    logic [QTY_W-1:0] amt;
    logic [ID_W-1:0]  rid;
    logic             closing;
    int unsigned      h;
    int unsigned      pos;
    int unsigned      hit;
    int unsigned      a;
    int unsigned      made;
    made = 0;
    case (o.kind)
      KIND_ADD: begin
        if (o.price != book_price) begin
          book_note(ST_MISMATCH, '0, '0, '0, '0, '0, 1'b1);
        end else if (book_count >= BOOK_DEPTH) begin
          book_note(ST_FULL, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          book_id[book_tail]  = o.order_id;
          book_qty[book_tail] = o.quantity;
          book_tail = (book_tail + 1) % BOOK_DEPTH;
          book_count++;
          book_note(ST_ADDED, '0, '0, '0, '0, '0, 1'b1);
        end
        made = 1;
      end
      KIND_MATCH: begin
        left = o.quantity;
        // Fill from the oldest order, one trade per fill, up to the trade cap
        while (left != 0 && book_count != 0 && made < MAX_TRADES) begin
          h   = book_head;
          rid = book_id[h];
          amt = (left < book_qty[h]) ? left : book_qty[h];
          left        = left - amt;
          book_qty[h] = book_qty[h] - amt;
          if (book_qty[h] == 0) begin
            book_head = (h + 1) % BOOK_DEPTH;
            book_count--;
          end
          made++;
          closing = (left == 0) || (book_count == 0) || (made == MAX_TRADES);
          if (o.side == SIDE_BUY)
            book_note(ST_TRADE, o.order_id, rid, amt, book_qty[h], left, closing);
          else
            book_note(ST_TRADE, rid, o.order_id, amt, book_qty[h], left, closing);
        end
        if (made == 0) begin
          book_note(ST_NOFILL, '0, '0, '0, '0, o.quantity, 1'b1);
          made = 1;
        end
      end
      KIND_CANCEL: begin
        hit = book_count;
        for (pos = 0; pos < book_count; pos++)
          if (hit == book_count && book_id[(book_head + pos) % BOOK_DEPTH] == o.order_id)
            hit = pos;
        if (hit == book_count) begin
          book_note(ST_NOTFOUND, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          // Close the gap: orders behind the hit move up one slot
          for (pos = hit; pos + 1 < book_count; pos++) begin
            a = (book_head + pos) % BOOK_DEPTH;
            book_id[a]  = book_id[(a + 1) % BOOK_DEPTH];
            book_qty[a] = book_qty[(a + 1) % BOOK_DEPTH];
          end
          book_tail = (book_tail + BOOK_DEPTH - 1) % BOOK_DEPTH;
          book_count--;
          book_note(ST_CANCELLED, '0, '0, '0, '0, '0, 1'b1);
        end
        made = 1;
      end
      default: made = 0;
    endcase
    return made;
  endfunction

  function automatic script_row_t script_row(input logic [1:0] kind, input logic [ID_W-1:0] id,
                                             input logic side, input logic [PRICE_W-1:0] price,
                                             input logic [QTY_W-1:0] qty, input logic typed,
                                             input status_e status,
                                             input logic [QTY_W-1:0] in_left, input logic empty);
    script_row_t r;
    r.ord.kind     = kind;
    r.ord.order_id = id;
    r.ord.side     = side;
    r.ord.price    = price;
    r.ord.quantity = qty;
    r.typed        = typed;
    r.exp_status   = status;
    r.exp_in_left  = in_left;
    r.exp_empty    = empty;
    return r;
  endfunction

  // Random order: mostly well-formed traffic at the level price, some noise
  function automatic order_t pick_order(input bit fill_only);
    order_t      o;
    int unsigned roll;
    roll = fill_only ? 0 : $urandom_range(0, 99);
    o.order_id = ($urandom_range(0, 99) < 35) ? $urandom_range(1, 6) : $urandom;
    o.side     = 1'($urandom_range(0, 1));
    o.price    = $urandom;
    o.quantity = $urandom;
    if (roll < 40) begin
      o.kind = KIND_ADD;
      case ($urandom_range(0, 9))
        0: ;
        1: o.price = book_price ^ (32'h1 << $urandom_range(0, 31));
        default: o.price = book_price;
      endcase
      case ($urandom_range(0, 9))
        0: o.quantity = '0;
        1, 2: ;
        default: o.quantity = $urandom_range(1, 40);
      endcase
    end else if (roll < 65) begin
      o.kind = KIND_MATCH;
      case ($urandom_range(0, 9))
        0: o.quantity = '0;
        1, 2: ;
        3, 4: o.quantity = $urandom_range(1, 400);
        default: o.quantity = $urandom_range(1, 60);
      endcase
    end else if (roll < 93) begin
      o.kind = KIND_CANCEL;
      if (book_count != 0 && $urandom_range(0, 9) < 8)
        o.order_id = book_id[(book_head + $urandom_range(0, book_count - 1)) % BOOK_DEPTH];
    end else begin
      o.kind = KIND_UNUSED;
    end
    return o;
  endfunction

  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (got === want)
      return 1'b1;
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    return 1'b0;
  endfunction

  // Offer one order and hold it until the transfer; then predict its results
  task automatic send_order(input order_t o, output int unsigned made);
    in_valid_i <= 1'b1;
    kind_i     <= o.kind;
    order_id_i <= o.order_id;
    side_i     <= o.side;
    price_i    <= o.price;
    quantity_i <= o.quantity;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    made = book_apply(o);
  endtask

  // Idle the sender now and then: a short gap, or a pause until drained
  task automatic sender_gap();
    if (!quiet_mode) begin
      if ($urandom_range(0, 99) < 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (awaited_reports.size() != 0) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < 25) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  endtask

  // Drain all results, then let any silent work finish
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_level_price(input logic [PRICE_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    book_price = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Open with a burst of adds to reach a full level, then mixed traffic
  task automatic run_random(input int unsigned target);
    order_t      o;
    int unsigned sent;
    int unsigned made;
    sent = 0;
    while (sent < target) begin
      o = pick_order(sent < FILL_BURST);
      sender_gap();
      send_order(o, made);
      if (o.kind != KIND_UNUSED)
        sent++;
    end
  endtask

  // Stall the result side in bursts; serve a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      stall_left   = HOLD_OFF_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet_mode && $urandom_range(0, 99) < 20) begin
      stall_left   = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : result_check
    fill_report_t want;
    bit           ok;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t ns: result with none expected, actual status %0d", $time, status_o);
        mismatch_count++;
      end else begin
        want = awaited_reports.pop_front();
        ok = field_ok("status", 32'(want.status), 32'(status_o))
           & field_ok("buy_id", want.buy_id, buy_id_o)
           & field_ok("sell_id", want.sell_id, sell_id_o)
           & field_ok("trade_qty", want.trade_qty, trade_qty_o)
           & field_ok("resting_left", want.resting_left, resting_left_o)
           & field_ok("incoming_left", want.incoming_left, incoming_left_o)
           & field_ok("level_empty", 32'(want.level_empty), 32'(level_empty_o))
           & field_ok("last", 32'(want.last), 32'(last_o));
        if (!ok)
          mismatch_count++;
      end
    end
  end

  // End the run when no transfer happens on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    script_row_t        row;
    fill_report_t       typed_report;
    logic [PRICE_W-1:0] phase_price [4];
    int unsigned        made;
    int unsigned        i;
    int unsigned        k;

    // Directed table at the reset level price of zero
    script = {script, script_row(KIND_MATCH, 32'h1, 1'b0, '0, 32'd5, 1'b1, ST_NOFILL,
                                 32'd5, 1'b1)};
    script = {script, script_row(KIND_CANCEL, 32'h7, 1'b0, '0, '0, 1'b1, ST_NOTFOUND,
                                 '0, 1'b1)};
    script = {script, script_row(KIND_ADD, 32'h9, 1'b0, 32'hFFFF_FFFF, 32'd3, 1'b1,
                                 ST_MISMATCH, '0, 1'b1)};
    script = {script, script_row(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 1'b0, ST_ADDED, '0, 1'b0)};
    script = {script, script_row(KIND_ADD, '0, 1'b0, '0, '0, 1'b1, ST_ADDED, '0, 1'b0)};
    script = {script, script_row(KIND_MATCH, 32'h2, 1'b1, '0, '0, 1'b1, ST_NOFILL,
                                 '0, 1'b0)};
    script = {script, script_row(KIND_ADD, 32'hFFFF_FFFF, 1'b1, '0, 32'd1, 1'b1, ST_ADDED,
                                 '0, 1'b0)};
    script = {script, script_row(KIND_ADD, 32'h5, 1'b0, '0, 32'd2, 1'b1, ST_ADDED,
                                 '0, 1'b0)};
    script = {script, script_row(KIND_ADD, 32'h5, 1'b0, '0, 32'd3, 1'b1, ST_ADDED,
                                 '0, 1'b0)};
    for (k = 10; k < 22; k++)
      script = {script, script_row(KIND_ADD, k, 1'b0, '0, k, 1'b1, ST_ADDED, '0, 1'b0)};
    script = {script, script_row(KIND_ADD, 32'd22, 1'b0, '0, 32'd1, 1'b1, ST_FULL,
                                 '0, 1'b0)};
    script = {script, script_row(KIND_CANCEL, 32'h5, 1'b0, '0, '0, 1'b1, ST_CANCELLED,
                                 '0, 1'b0)};
    script = {script, script_row(KIND_CANCEL, 32'h1234_5678, 1'b0, '0, '0, 1'b1,
                                 ST_NOTFOUND, '0, 1'b0)};
    script = {script, script_row(KIND_ADD, 32'h8000_0001, 1'b0, '0, 32'd4, 1'b1, ST_ADDED,
                                 '0, 1'b0)};
    // Sixteen fills clear the level and the rest of the incoming order is dropped
    script = {script, script_row(KIND_MATCH, 32'hA5A5_5A5A, 1'b1, '0, 32'hFFFF_FFFF, 1'b0,
                                 ST_TRADE, '0, 1'b0)};

    phase_price[0] = 32'hFFFF_FFFF;
    phase_price[1] = $urandom;
    phase_price[2] = '0;
    phase_price[3] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table; typed rows replace the prediction
    for (i = 0; i < script.size(); i++) begin
      row = script[i];
      sender_gap();
      send_order(row.ord, made);
      if (row.typed) begin
        for (k = 0; k < made; k++)
          void'(awaited_reports.pop_back());
        typed_report               = '0;
        typed_report.status        = row.exp_status;
        typed_report.incoming_left = row.exp_in_left;
        typed_report.level_empty   = row.exp_empty;
        typed_report.last          = 1'b1;
        awaited_reports = {awaited_reports, typed_report};
      end
    end

    // Random phases, one level price each; long hold-off first, no idling last
    for (i = 0; i < 4; i++) begin
      settle_block();
      write_level_price(phase_price[i]);
      if (i == 0)
        hold_off_req = 1'b1;
      if (i == 3)
        quiet_mode = 1'b1;
      run_random(ITEMS_PER_PHASE);
    end
    settle_block();

    if (mismatch_count == 0 && awaited_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
